@@ hdl/ptrs_pkg.sv @@
// Shared types and field widths for the priority task ready scheduler.
package ptrs_pkg;

    localparam int REQ_W    = 2;
    localparam int TGT_W    = 4;
    localparam int EVT_W    = 32;
    localparam int MASK_W   = 16;
    localparam int RUN_W    = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET_EVENT  = 2'd0,
        REQ_WAIT_EVENT = 2'd1,
        REQ_RESCHEDULE = 2'd2,
        REQ_LOAD_MASK  = 2'd3
    } t_req;

endpackage

@@ hdl/ptrs_prio_enc.sv @@
// Highest-set-bit priority encoder over the ready mask.
module ptrs_prio_enc #(
    parameter int WIDTH = 16,
    parameter int IDX_W = 4
) (
    input  logic [WIDTH-1:0] i_mask,
    output logic [IDX_W-1:0] o_idx
);

    // Empty mask falls back to index zero, the idle task.
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (i_mask[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

endmodule

@@ hdl/priority_task_ready_scheduler.sv @@
// Top level of the priority task ready scheduler.
//
// Takes one request word per cycle while the output side takes results,
// and returns one result word for each request. All state (ready mask,
// per-task event words, running task, pending reschedule flag) updates in
// the cycle a request is accepted, so the next request sees it at once.
// The result sits in an output register and shows from the next cycle; a
// new request is accepted whenever it is empty or being taken that cycle.
// The combinational path runs from the request ports through the event word
// update and a priority encode over TASK_COUNT bits into the registers.
// Reset is synchronous and leaves every task ready, no events, idle running.
module priority_task_ready_scheduler #(
    parameter int TASK_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ptrs_pkg::REQ_W-1:0]    i_req_type,
    input  logic [ptrs_pkg::TGT_W-1:0]    i_target_task,
    input  logic [ptrs_pkg::EVT_W-1:0]    i_event_bits,
    input  logic                          i_from_interrupt,
    input  logic                          i_wait_after,
    input  logic [ptrs_pkg::MASK_W-1:0]   i_mask_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptrs_pkg::EVT_W-1:0]    o_events_out,
    output logic                          o_blocked,
    output logic [ptrs_pkg::RUN_W-1:0]    o_running_task,
    output logic [ptrs_pkg::MASK_W-1:0]   o_ready_out,
    output logic                          o_resched_pending
);

    localparam int ID_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    logic [TASK_COUNT-1:0]          r_ready_mask;
    logic [ptrs_pkg::EVT_W-1:0]     r_evt [TASK_COUNT];
    logic [ID_W-1:0]                r_cur;
    logic                           r_pend;

    logic                           r_valid;
    logic [ptrs_pkg::EVT_W-1:0]     r_events_out;
    logic                           r_blocked;
    logic [ptrs_pkg::RUN_W-1:0]     r_running_task;
    logic [ptrs_pkg::MASK_W-1:0]    r_ready_out;
    logic                           r_resched_pending;

    logic [TASK_COUNT-1:0]          n_ready_mask;
    logic [ptrs_pkg::EVT_W-1:0]     n_evt [TASK_COUNT];
    logic [ID_W-1:0]                n_cur;
    logic                           n_pend;

    logic                           accept;
    ptrs_pkg::t_req                 req;
    logic                           tgt_ok;
    logic [TASK_COUNT-1:0]          tgt_bit;
    logic [TASK_COUNT-1:0]          cur_bit;
    logic [TASK_COUNT+ptrs_pkg::EVT_W-1:0] mask_ext;
    logic [ptrs_pkg::EVT_W-1:0]     cur_evt;
    logic [ptrs_pkg::EVT_W-1:0]     evt_out;
    logic                           blk;
    logic                           do_switch;
    logic                           pend_pre;
    logic [ID_W-1:0]                top_id;
    logic [TASK_COUNT+ptrs_pkg::MASK_W-1:0] ready_ext;
    logic [ID_W+ptrs_pkg::RUN_W-1:0] run_ext;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign req     = ptrs_pkg::t_req'(i_req_type);

    assign tgt_ok   = (32'(i_target_task) < TASK_COUNT);
    assign tgt_bit  = tgt_ok ? (TASK_COUNT'(1) << i_target_task) : '0;
    assign cur_bit  = TASK_COUNT'(1) << r_cur;
    assign mask_ext = {{(TASK_COUNT+ptrs_pkg::EVT_W-ptrs_pkg::MASK_W){1'b0}}, i_mask_value};

    always_comb begin
        logic                  do_wait;
        logic [TASK_COUNT-1:0] wait_bit;
        do_wait      = 1'b0;
        wait_bit     = '0;
        n_ready_mask = r_ready_mask;
        n_evt        = r_evt;
        pend_pre     = r_pend;
        do_switch    = 1'b0;
        evt_out      = '0;
        blk          = 1'b0;
        cur_evt      = '0;
        unique case (req)
            ptrs_pkg::REQ_SET_EVENT: begin
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (tgt_ok && (32'(i_target_task) == i)) begin
                        n_evt[i] = r_evt[i] | i_event_bits;
                    end
                end
                priority if (i_from_interrupt) begin
                    // ready the receiver only, switch later
                    n_ready_mask = n_ready_mask | tgt_bit;
                    pend_pre     = 1'b1;
                end else if (i_wait_after) begin
                    do_wait  = 1'b1;
                    wait_bit = tgt_bit;
                end else begin
                    n_ready_mask = n_ready_mask | tgt_bit;
                    do_switch    = 1'b1;
                end
            end
            ptrs_pkg::REQ_WAIT_EVENT: begin
                do_wait  = 1'b1;
                wait_bit = TASK_COUNT'(1);
            end
            ptrs_pkg::REQ_RESCHEDULE: begin
                do_switch = 1'b1;
            end
            ptrs_pkg::REQ_LOAD_MASK: begin
                n_ready_mask = mask_ext[TASK_COUNT-1:0] | TASK_COUNT'(1);
                do_switch    = 1'b1;
            end
        endcase
        if (do_wait) begin
            cur_evt = n_evt[r_cur];
            if (cur_evt != '0) begin
                // return and clear own events, no switch
                evt_out      = cur_evt;
                n_evt[r_cur] = '0;
            end else begin
                n_ready_mask = (n_ready_mask & ~cur_bit) | wait_bit;
                do_switch    = 1'b1;
                blk          = 1'b1;
            end
        end
    end

    ptrs_prio_enc #(
        .WIDTH (TASK_COUNT),
        .IDX_W (ID_W)
    ) u_prio_enc (
        .i_mask (n_ready_mask),
        .o_idx  (top_id)
    );

    assign n_cur  = do_switch ? top_id : r_cur;
    assign n_pend = do_switch ? 1'b0 : pend_pre;

    assign ready_ext = {{ptrs_pkg::MASK_W{1'b0}}, n_ready_mask};
    assign run_ext   = {{ptrs_pkg::RUN_W{1'b0}}, n_cur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_mask <= '1;
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_evt[i] <= '0;
            end
            r_cur   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_ready_mask <= n_ready_mask;
                r_evt        <= n_evt;
                r_cur        <= n_cur;
                r_pend       <= n_pend;
                r_valid      <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result word holds until taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_events_out      <= evt_out;
            r_blocked         <= blk;
            r_running_task    <= run_ext[ptrs_pkg::RUN_W-1:0];
            r_ready_out       <= ready_ext[ptrs_pkg::MASK_W-1:0];
            r_resched_pending <= n_pend;
        end
    end

    assign o_valid           = r_valid;
    assign o_events_out      = r_events_out;
    assign o_blocked         = r_blocked;
    assign o_running_task    = r_running_task;
    assign o_ready_out       = r_ready_out;
    assign o_resched_pending = r_resched_pending;

endmodule
